>>> rtl/core/jrns_pkg.sv
package jrns_pkg;

    // field widths
    localparam int WORD_W      = 32;
    localparam int SLOT_W      = 13;
    localparam int SLOTS_DEF   = 8192;

    // record queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // checksum
    localparam logic [WORD_W-1:0] CRC_POLY = 32'hEDB88320;
    localparam logic [WORD_W-1:0] ALL_ONES = 32'hFFFFFFFF;

    // record type markers
    localparam logic [WORD_W-1:0] MAGIC_CURRENT = 32'h4B455933;
    localparam logic [WORD_W-1:0] MAGIC_LEGACY  = 32'h4B455932;

    // value rules
    localparam logic [WORD_W-1:0] CHECKPOINT_STEP  = 32'd10000;
    localparam logic [WORD_W-1:0] LEGACY_STEP      = 32'd100;
    localparam logic [WORD_W-1:0] LEGACY_COUNT_MAX = 32'd1000000000;

    // reciprocal constants: n / 100 and n / 10000 exact for any 32-bit n
    localparam logic [WORD_W-1:0] DIV100_MUL   = 32'h51EB851F;
    localparam int                DIV100_SHIFT = 37;
    localparam logic [WORD_W-1:0] DIV10K_MUL   = 32'hD1B71759;
    localparam int                DIV10K_SHIFT = 45;

    typedef enum logic [1:0] {
        MAG_OTHER,
        MAG_CURRENT,
        MAG_LEGACY
    } t_magic;

    // classified record as it travels through the queue
    typedef struct packed {
        logic              start_scan;
        logic [SLOT_W-1:0] slot;
        logic              erased;
        t_magic            magic;
        logic              base_ok;
        logic [WORD_W-1:0] crc;
        logic [WORD_W-1:0] seq;
        logic [WORD_W-1:0] cnt;
        logic [WORD_W-1:0] chk;
    } t_rec;

    // reflected crc-32 over one word, low byte first
    function automatic logic [WORD_W-1:0] crc_word(input logic [WORD_W-1:0] crc_in,
                                                   input logic [WORD_W-1:0] word);
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] w;
        c = crc_in;
        w = word;
        for (int b = 0; b < 4; b++) begin
            c = c ^ {24'b0, w[7:0]};
            w = w >> 8;
            for (int k = 0; k < 8; k++) begin
                c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/core/jrns_front.sv
module jrns_front (
    input  logic                                 i_start_scan,
    input  logic [jrns_pkg::SLOT_W-1:0]          i_slot_index,
    input  logic [jrns_pkg::WORD_W-1:0]          i_rec_magic,
    input  logic [jrns_pkg::WORD_W-1:0]          i_rec_sequence,
    input  logic [jrns_pkg::WORD_W-1:0]          i_rec_count,
    input  logic [jrns_pkg::WORD_W-1:0]          i_rec_checksum,
    output jrns_pkg::t_rec                       o_rec
);
    import jrns_pkg::*;

    t_magic magic_class;

    // record type from the marker word
    always_comb begin
        if (i_rec_magic == MAGIC_CURRENT) begin
            magic_class = MAG_CURRENT;
        end else if (i_rec_magic == MAGIC_LEGACY) begin
            magic_class = MAG_LEGACY;
        end else begin
            magic_class = MAG_OTHER;
        end
    end

    // classify and start the checksum with the marker word
    always_comb begin
        o_rec.start_scan = i_start_scan;
        o_rec.slot       = i_slot_index;
        o_rec.erased     = (i_rec_magic == ALL_ONES) && (i_rec_sequence == ALL_ONES) &&
                           (i_rec_count == ALL_ONES) && (i_rec_checksum == ALL_ONES);
        o_rec.magic      = magic_class;
        o_rec.base_ok    = (i_rec_count != '0) && (i_rec_sequence != '0) &&
                           (i_rec_sequence <= i_rec_count);
        o_rec.crc        = crc_word(ALL_ONES, i_rec_magic);
        o_rec.seq        = i_rec_sequence;
        o_rec.cnt        = i_rec_count;
        o_rec.chk        = i_rec_checksum;
    end

endmodule

>>> rtl/core/jrns_queue.sv
module jrns_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  jrns_pkg::t_rec i_rec,
    output logic           o_full,
    output logic           o_valid,
    output jrns_pkg::t_rec o_rec,
    input  logic           i_pop
);
    import jrns_pkg::*;

    t_rec              r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic [QPTR_W-1:0] n_wr;
    logic [QPTR_W-1:0] n_rd;
    logic [QCNT_W-1:0] n_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rec   = r_entry[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointer and fill count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr] <= i_rec;
        end
    end

endmodule

>>> rtl/core/jrns_back.sv
module jrns_back #(
    parameter int SLOTS_PER_SECTOR = jrns_pkg::SLOTS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    input  jrns_pkg::t_rec                          i_rec,
    output logic                                    o_stall,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic                                    o_is_erased,
    output logic                                    o_is_valid,
    output logic                                    o_took_record,
    output logic [jrns_pkg::WORD_W-1:0]             o_newest_sequence,
    output logic [jrns_pkg::WORD_W-1:0]             o_newest_count,
    output logic [$clog2(SLOTS_PER_SECTOR+1)-1:0]   o_free_slot
);
    import jrns_pkg::*;

    localparam int FREE_W = $clog2(SLOTS_PER_SECTOR + 1);
    localparam int CALC_W = (FREE_W > SLOT_W + 1) ? FREE_W : SLOT_W + 1;
    localparam int Q100_W = 2 * WORD_W - DIV100_SHIFT;
    localparam int Q10K_W = 2 * WORD_W - DIV10K_SHIFT;

    // stage 1: sequence word checksum, reciprocal products
    logic                  r_s1_v;
    t_rec                  r_s1_rec;
    logic [2*WORD_W-1:0]   r_s1_p100;
    logic [2*WORD_W-1:0]   r_s1_p10k;
    // stage 2: verdict
    logic                  r_s2_v;
    logic                  r_s2_start;
    logic [SLOT_W-1:0]     r_s2_slot;
    logic                  r_s2_erased;
    logic                  r_s2_valid;
    logic [WORD_W-1:0]     r_s2_seq;
    logic [WORD_W-1:0]     r_s2_cnt;
    // result beat and scan state
    logic                  r_o_v;
    logic                  r_erased;
    logic                  r_isvalid;
    logic                  r_took;
    logic [WORD_W-1:0]     r_best_seq;
    logic [WORD_W-1:0]     r_best_cnt;
    logic [FREE_W-1:0]     r_free;

    logic                  out_rdy;
    logic                  s2_rdy;
    logic                  s1_rdy;

    t_rec                  s1_in;

    logic [WORD_W-1:0]     crc_fin;
    logic [Q100_W-1:0]     q100;
    logic [Q10K_W-1:0]     q10k;
    logic [WORD_W-1:0]     m100;
    logic [WORD_W-1:0]     m10k;
    logic [WORD_W-1:0]     seq_max;
    logic                  legacy_ok;
    logic                  rules_ok;
    logic                  n_s2_valid;

    logic [WORD_W-1:0]     base_seq;
    logic [WORD_W-1:0]     base_cnt;
    logic [FREE_W-1:0]     base_free;
    logic [CALC_W-1:0]     nxt_calc;
    logic [FREE_W-1:0]     nxt_free;
    logic                  newer;
    logic                  n_took;
    logic [WORD_W-1:0]     n_best_seq;
    logic [WORD_W-1:0]     n_best_cnt;
    logic [FREE_W-1:0]     n_free;

    // pipeline advance
    assign out_rdy = !r_o_v || !i_stall;
    assign s2_rdy  = !r_s2_v || out_rdy;
    assign s1_rdy  = !r_s1_v || s2_rdy;
    assign o_stall = !s1_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            if (s1_rdy) begin
                r_s1_v <= i_valid;
            end
            if (s2_rdy) begin
                r_s2_v <= r_s1_v;
            end
            if (out_rdy) begin
                r_o_v <= r_s2_v;
            end
        end
    end

    // stage 1 input with the sequence word folded into the checksum
    always_comb begin
        s1_in     = i_rec;
        s1_in.crc = crc_word(i_rec.crc, i_rec.seq);
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (s1_rdy && i_valid) begin
            r_s1_rec     <= s1_in;
            r_s1_p100    <= {{WORD_W{1'b0}}, i_rec.cnt} * {{WORD_W{1'b0}}, DIV100_MUL};
            r_s1_p10k    <= {{WORD_W{1'b0}}, i_rec.cnt} * {{WORD_W{1'b0}}, DIV10K_MUL};
        end
    end

    // stage 2: finish checksum, remainders and value rules
    always_comb begin
        crc_fin   = ~crc_word(r_s1_rec.crc, r_s1_rec.cnt);
        q100      = r_s1_p100[2*WORD_W-1:DIV100_SHIFT];
        q10k      = r_s1_p10k[2*WORD_W-1:DIV10K_SHIFT];
        m100      = WORD_W'(q100) * LEGACY_STEP;
        m10k      = WORD_W'(q10k) * CHECKPOINT_STEP;
        if (r_s1_rec.cnt < LEGACY_STEP) begin
            seq_max = (r_s1_rec.cnt == 32'd1) ? 32'd1 : 32'd2;
        end else begin
            seq_max = WORD_W'(q100) + 32'd2;
        end
        legacy_ok = ((r_s1_rec.cnt == 32'd1) || (r_s1_rec.cnt == 32'd10) ||
                     (r_s1_rec.cnt == m100)) &&
                    (r_s1_rec.cnt <= LEGACY_COUNT_MAX) &&
                    (r_s1_rec.seq <= seq_max);
        case (r_s1_rec.magic)
            MAG_LEGACY:  rules_ok = legacy_ok;
            MAG_CURRENT: rules_ok = (r_s1_rec.cnt == m10k);
            default:     rules_ok = 1'b0;
        endcase
        n_s2_valid = r_s1_rec.base_ok && rules_ok && (r_s1_rec.chk == crc_fin);
    end

    always_ff @(posedge i_clk) begin
        if (s2_rdy && r_s1_v) begin
            r_s2_start  <= r_s1_rec.start_scan;
            r_s2_slot   <= r_s1_rec.slot;
            r_s2_erased <= r_s1_rec.erased;
            r_s2_valid  <= n_s2_valid;
            r_s2_seq    <= r_s1_rec.seq;
            r_s2_cnt    <= r_s1_rec.cnt;
        end
    end

    // newest record and free slot, in beat order
    always_comb begin
        base_seq  = r_s2_start ? '0 : r_best_seq;
        base_cnt  = r_s2_start ? '0 : r_best_cnt;
        base_free = r_s2_start ? '0 : r_free;
        nxt_calc  = CALC_W'(r_s2_slot) + 1'b1;
        if (nxt_calc > CALC_W'(SLOTS_PER_SECTOR)) begin
            nxt_free = FREE_W'(SLOTS_PER_SECTOR);
        end else begin
            nxt_free = FREE_W'(nxt_calc);
        end
        newer      = (r_s2_seq != base_seq) ? (r_s2_seq > base_seq) : (r_s2_cnt > base_cnt);
        n_took     = r_s2_valid && newer;
        n_best_seq = n_took ? r_s2_seq : base_seq;
        n_best_cnt = n_took ? r_s2_cnt : base_cnt;
        n_free     = r_s2_erased ? base_free : nxt_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_seq <= '0;
            r_best_cnt <= '0;
            r_free     <= '0;
        end else if (out_rdy && r_s2_v) begin
            r_best_seq <= n_best_seq;
            r_best_cnt <= n_best_cnt;
            r_free     <= n_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_rdy && r_s2_v) begin
            r_erased  <= r_s2_erased;
            r_isvalid <= r_s2_valid;
            r_took    <= n_took;
        end
    end

    assign o_valid           = r_o_v;
    assign o_is_erased       = r_erased;
    assign o_is_valid        = r_isvalid;
    assign o_took_record     = r_took;
    assign o_newest_sequence = r_best_seq;
    assign o_newest_count    = r_best_cnt;
    assign o_free_slot       = r_free;

endmodule

>>> rtl/core/journal_record_newest_scan.sv
// channel   direction  handshake          beat
// record    in         i_valid / o_stall  i_start_scan, i_slot_index, i_rec_magic,
//                                         i_rec_sequence, i_rec_count, i_rec_checksum
// result    out        o_valid / i_stall  o_is_erased, o_is_valid, o_took_record,
//                                         o_newest_sequence, o_newest_count, o_free_slot
//
// one record beat per cycle sustained while the result side does not stall; a beat passes
// the queue slot, the checksum and multiply stage, the verdict stage and the result register.
// a 4-entry record queue sits in front of the three-stage back pipeline, so the
// record side keeps taking beats while the result side stalls until the queue fills.
// reset is synchronous; it empties the queue and pipeline and clears the running best
// and free slot to zero.
module journal_record_newest_scan #(
    parameter int SLOTS_PER_SECTOR = jrns_pkg::SLOTS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic                                    i_start_scan,
    input  logic [jrns_pkg::SLOT_W-1:0]             i_slot_index,
    input  logic [jrns_pkg::WORD_W-1:0]             i_rec_magic,
    input  logic [jrns_pkg::WORD_W-1:0]             i_rec_sequence,
    input  logic [jrns_pkg::WORD_W-1:0]             i_rec_count,
    input  logic [jrns_pkg::WORD_W-1:0]             i_rec_checksum,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic                                    o_is_erased,
    output logic                                    o_is_valid,
    output logic                                    o_took_record,
    output logic [jrns_pkg::WORD_W-1:0]             o_newest_sequence,
    output logic [jrns_pkg::WORD_W-1:0]             o_newest_count,
    output logic [$clog2(SLOTS_PER_SECTOR+1)-1:0]   o_free_slot
);
    import jrns_pkg::*;

    localparam int FREE_W = $clog2(SLOTS_PER_SECTOR + 1);

    t_rec front_rec;
    t_rec queue_rec;
    logic queue_full;
    logic queue_valid;
    logic back_stall;

    // classify incoming beat
    jrns_front u_front (
        .i_start_scan   (i_start_scan),
        .i_slot_index   (i_slot_index),
        .i_rec_magic    (i_rec_magic),
        .i_rec_sequence (i_rec_sequence),
        .i_rec_count    (i_rec_count),
        .i_rec_checksum (i_rec_checksum),
        .o_rec          (front_rec)
    );

    // decoupling queue
    jrns_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_rec   (front_rec),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_rec   (queue_rec),
        .i_pop   (!back_stall)
    );

    assign o_stall = queue_full;

    // checksum, value rules and running best
    jrns_back #(
        .SLOTS_PER_SECTOR (SLOTS_PER_SECTOR)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (queue_valid),
        .i_rec             (queue_rec),
        .o_stall           (back_stall),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_is_erased       (o_is_erased),
        .o_is_valid        (o_is_valid),
        .o_took_record     (o_took_record),
        .o_newest_sequence (o_newest_sequence),
        .o_newest_count    (o_newest_count),
        .o_free_slot       (o_free_slot)
    );

    // a record taken as newest must have passed its checks
    a_took_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_took_record |-> o_is_valid)
        else $error("newest record taken without passing checks");

    // an erased record can never pass the value rules
    a_erased_not_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_erased |-> !o_is_valid)
        else $error("erased record reported valid");

    // a taken record carries a nonzero sequence
    a_took_nonzero_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_took_record |-> o_newest_sequence != '0)
        else $error("newest record with zero sequence");

    // free slot saturates at the sector size
    a_free_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_free_slot <= FREE_W'(SLOTS_PER_SECTOR))
        else $error("free slot beyond sector");

endmodule

>>> test/journal_record_newest_scan_check.sv
module journal_record_newest_scan_check
    import jrns_pkg::*;
#(
    parameter int SLOTS  = jrns_pkg::SLOTS_DEF,
    parameter int FREE_W = $clog2(jrns_pkg::SLOTS_DEF + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rec_valid,
    input  logic              i_rec_stall,
    input  logic              i_start_scan,
    input  logic [SLOT_W-1:0] i_slot_index,
    input  logic [WORD_W-1:0] i_rec_magic,
    input  logic [WORD_W-1:0] i_rec_sequence,
    input  logic [WORD_W-1:0] i_rec_count,
    input  logic [WORD_W-1:0] i_rec_checksum,
    input  logic              i_res_valid,
    input  logic              i_res_stall,
    input  logic              i_is_erased,
    input  logic              i_is_valid,
    input  logic              i_took_record,
    input  logic [WORD_W-1:0] i_newest_sequence,
    input  logic [WORD_W-1:0] i_newest_count,
    input  logic [FREE_W-1:0] i_free_slot,
    output int                o_mismatches,
    output int                o_outstanding
);

    typedef struct {
        logic              erased;
        logic              valid;
        logic              took;
        logic [WORD_W-1:0] seq;
        logic [WORD_W-1:0] cnt;
        logic [FREE_W-1:0] free;
    } t_scan_verdict;

    // running scan state as the block should hold it
    logic [WORD_W-1:0] best_seq;
    logic [WORD_W-1:0] best_cnt;
    logic [FREE_W-1:0] free_after;

    t_scan_verdict verdicts_due[$];
    int            mismatch_total;

    // reflected crc-32 over magic, sequence, count, bit serial, low bit first
    function automatic logic [WORD_W-1:0] record_crc(input logic [WORD_W-1:0] magic, seq, cnt);
        logic [3*WORD_W-1:0] bits;
        logic [WORD_W-1:0]   c;
        logic                fb;
        bits = {cnt, seq, magic};
        c    = ALL_ONES;
        for (int i = 0; i < 3 * WORD_W; i++) begin
            fb = c[0] ^ bits[i];
            c  = c >> 1;
            if (fb) c = c ^ CRC_POLY;
        end
        return ~c;
    endfunction

    // value rules for current and legacy markers
    function automatic logic rules_pass(input logic [WORD_W-1:0] magic, seq, cnt);
        logic              mark;
        logic [WORD_W-1:0] seq_lim;
        if (cnt == 0 || seq == 0 || seq > cnt) return 1'b0;
        if (magic == MAGIC_LEGACY) begin
            mark = (cnt == 1) || (cnt == 10) || (cnt % LEGACY_STEP == 0);
            if (cnt < LEGACY_STEP) seq_lim = (cnt == 1) ? 1 : 2;
            else seq_lim = cnt / LEGACY_STEP + 2;
            return mark && (cnt <= LEGACY_COUNT_MAX) && (seq <= seq_lim);
        end
        return (magic == MAGIC_CURRENT) && (cnt % CHECKPOINT_STEP == 0);
    endfunction

    // advance the scan state by one record and give the result it should produce
    task automatic judge_record(input logic start, input logic [SLOT_W-1:0] slot,
                                input logic [WORD_W-1:0] magic, seq, cnt, chk,
                                output t_scan_verdict v);
        logic [FREE_W:0] nxt;
        if (start) begin
            best_seq   = '0;
            best_cnt   = '0;
            free_after = '0;
        end
        v.erased = (magic == ALL_ONES) && (seq == ALL_ONES) && (cnt == ALL_ONES) &&
                   (chk == ALL_ONES);
        if (!v.erased) begin
            nxt = (FREE_W + 1)'(slot) + 1'b1;
            if (nxt > (FREE_W + 1)'(SLOTS)) nxt = (FREE_W + 1)'(SLOTS);
            free_after = nxt[FREE_W-1:0];
        end
        v.valid = rules_pass(magic, seq, cnt) && (chk == record_crc(magic, seq, cnt));
        v.took  = 1'b0;
        if (v.valid && ((seq != best_seq) ? (seq > best_seq) : (cnt > best_cnt))) begin
            best_seq = seq;
            best_cnt = cnt;
            v.took   = 1'b1;
        end
        v.seq  = best_seq;
        v.cnt  = best_cnt;
        v.free = free_after;
    endtask

    // one line per mismatch
    task automatic report_mismatch(input string field, input logic [WORD_W-1:0] seen, due);
        $display("mismatch %s: got 0x%08h, want 0x%08h", field, seen, due);
        mismatch_total++;
    endtask

    t_scan_verdict want;
    t_scan_verdict next_want;

    // compare result beats, then predict record beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            best_seq   = '0;
            best_cnt   = '0;
            free_after = '0;
            verdicts_due.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (verdicts_due.size() == 0) begin
                    report_mismatch("result beat with none due", '0, '0);
                end else begin
                    want = verdicts_due.pop_front();
                    if (i_is_erased !== want.erased)
                        report_mismatch("is_erased", WORD_W'(i_is_erased),
                                        WORD_W'(want.erased));
                    if (i_is_valid !== want.valid)
                        report_mismatch("is_valid", WORD_W'(i_is_valid),
                                        WORD_W'(want.valid));
                    if (i_took_record !== want.took)
                        report_mismatch("took_record", WORD_W'(i_took_record),
                                        WORD_W'(want.took));
                    if (i_newest_sequence !== want.seq)
                        report_mismatch("newest_sequence", i_newest_sequence, want.seq);
                    if (i_newest_count !== want.cnt)
                        report_mismatch("newest_count", i_newest_count, want.cnt);
                    if (i_free_slot !== want.free)
                        report_mismatch("free_slot", WORD_W'(i_free_slot),
                                        WORD_W'(want.free));
                end
            end
            if (i_rec_valid && !i_rec_stall) begin
                judge_record(i_start_scan, i_slot_index, i_rec_magic, i_rec_sequence,
                             i_rec_count, i_rec_checksum, next_want);
                verdicts_due.push_back(next_want);
            end
        end
        o_mismatches  <= mismatch_total;
        o_outstanding <= verdicts_due.size();
    end

endmodule

>>> test/journal_record_newest_scan_tb.sv
module journal_record_newest_scan_tb
    import jrns_pkg::*;
;

    localparam int FREE_W = $clog2(SLOTS_DEF + 1);

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_valid        = 1'b0;
    logic              o_stall;
    logic              i_start_scan   = 1'b0;
    logic [SLOT_W-1:0] i_slot_index   = '0;
    logic [WORD_W-1:0] i_rec_magic    = '0;
    logic [WORD_W-1:0] i_rec_sequence = '0;
    logic [WORD_W-1:0] i_rec_count    = '0;
    logic [WORD_W-1:0] i_rec_checksum = '0;
    logic              o_valid;
    logic              i_stall        = 1'b0;
    logic              o_is_erased;
    logic              o_is_valid;
    logic              o_took_record;
    logic [WORD_W-1:0] o_newest_sequence;
    logic [WORD_W-1:0] o_newest_count;
    logic [FREE_W-1:0] o_free_slot;

    int mismatch_count;
    int verdicts_pending;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // journal position for well-formed record runs
    logic [WORD_W-1:0] journal_seq = 1;
    logic [SLOT_W-1:0] slot_next   = '0;

    journal_record_newest_scan uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_start_scan      (i_start_scan),
        .i_slot_index      (i_slot_index),
        .i_rec_magic       (i_rec_magic),
        .i_rec_sequence    (i_rec_sequence),
        .i_rec_count       (i_rec_count),
        .i_rec_checksum    (i_rec_checksum),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_is_erased       (o_is_erased),
        .o_is_valid        (o_is_valid),
        .o_took_record     (o_took_record),
        .o_newest_sequence (o_newest_sequence),
        .o_newest_count    (o_newest_count),
        .o_free_slot       (o_free_slot)
    );

    journal_record_newest_scan_check verdict_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_rec_valid       (i_valid),
        .i_rec_stall       (o_stall),
        .i_start_scan      (i_start_scan),
        .i_slot_index      (i_slot_index),
        .i_rec_magic       (i_rec_magic),
        .i_rec_sequence    (i_rec_sequence),
        .i_rec_count       (i_rec_count),
        .i_rec_checksum    (i_rec_checksum),
        .i_res_valid       (o_valid),
        .i_res_stall       (i_stall),
        .i_is_erased       (o_is_erased),
        .i_is_valid        (o_is_valid),
        .i_took_record     (o_took_record),
        .i_newest_sequence (o_newest_sequence),
        .i_newest_count    (o_newest_count),
        .i_free_slot       (o_free_slot),
        .o_mismatches      (mismatch_count),
        .o_outstanding     (verdicts_pending)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99, 0) < rx_idle_pct);
    end

    // checksum used to seal stimulus records
    function automatic logic [WORD_W-1:0] seal_crc(input logic [WORD_W-1:0] magic, seq, cnt);
        logic [3*WORD_W-1:0] bits;
        logic [WORD_W-1:0]   c;
        bits = {cnt, seq, magic};
        c    = ALL_ONES;
        for (int i = 0; i < 3 * WORD_W; i++)
            c = (c >> 1) ^ ((c[0] ^ bits[i]) ? CRC_POLY : '0);
        return ~c;
    endfunction

    // present one record beat and hold it until taken
    task automatic send_record(input logic start, input logic [SLOT_W-1:0] slot,
                               input logic [WORD_W-1:0] magic, seq, cnt, chk);
        @(negedge i_clk);
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_start_scan   <= start;
        i_slot_index   <= slot;
        i_rec_magic    <= magic;
        i_rec_sequence <= seq;
        i_rec_count    <= cnt;
        i_rec_checksum <= chk;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
    endtask

    task automatic send_signed(input logic start, input logic [SLOT_W-1:0] slot,
                               input logic [WORD_W-1:0] magic, seq, cnt);
        send_record(start, slot, magic, seq, cnt, seal_crc(magic, seq, cnt));
    endtask

    // values that pass the rules: mostly a journal run, sometimes wide random
    task automatic valid_fields(output logic [WORD_W-1:0] magic, seq, cnt);
        logic              wide;
        logic [WORD_W-1:0] seq_lim;
        wide = ($urandom_range(3, 0) == 0);
        if ($urandom_range(1, 0) == 1) begin
            magic = MAGIC_CURRENT;
            cnt   = CHECKPOINT_STEP * $urandom_range(429496, 1);
            seq   = wide ? $urandom_range(cnt, 1) : journal_seq;
        end else begin
            magic = MAGIC_LEGACY;
            if (wide) begin
                case ($urandom_range(3, 0))
                    0: cnt = 1;
                    1: cnt = 10;
                    default: cnt = LEGACY_STEP * $urandom_range(10000000, 1);
                endcase
                if (cnt < LEGACY_STEP) seq_lim = (cnt == 1) ? 1 : 2;
                else seq_lim = cnt / LEGACY_STEP + 2;
                seq = $urandom_range(seq_lim, 1);
            end else begin
                cnt = LEGACY_STEP * (journal_seq + $urandom_range(20, 0));
                seq = journal_seq;
            end
        end
        // zero step repeats a sequence so count decides
        journal_seq = journal_seq + $urandom_range(2, 0);
    endtask

    // values that break at least one rule; the caller seals them with a correct checksum
    task automatic broken_fields(output logic [WORD_W-1:0] magic, seq, cnt);
        logic [WORD_W-1:0] k;
        case ($urandom_range(6, 0))
            0: begin
                valid_fields(magic, seq, cnt);
                seq = '0;
            end
            1: begin
                valid_fields(magic, seq, cnt);
                cnt = '0;
            end
            2: begin
                magic = $urandom_range(1, 0) ? MAGIC_CURRENT : MAGIC_LEGACY;
                cnt   = $urandom_range(32'hFFFF_FFFE, 1);
                seq   = cnt + 1;
            end
            3: begin
                magic = MAGIC_CURRENT;
                cnt   = CHECKPOINT_STEP * $urandom_range(429495, 1) + $urandom_range(9999, 1);
                seq   = 1;
            end
            4: begin
                magic = MAGIC_LEGACY;
                cnt   = LEGACY_STEP * $urandom_range(42949672, 10000001);
                seq   = 1;
            end
            5: begin
                magic = MAGIC_LEGACY;
                k     = $urandom_range(10000000, 1);
                cnt   = LEGACY_STEP * k;
                seq   = k + 3;
            end
            default: begin
                magic = MAGIC_LEGACY;
                cnt   = LEGACY_STEP * $urandom_range(1000, 0) + $urandom_range(99, 2);
                if (cnt == 10) cnt = 11;
                seq   = 1;
            end
        endcase
    endtask

    // one random record beat
    task automatic random_record();
        logic              start;
        logic [SLOT_W-1:0] slot;
        logic [WORD_W-1:0] magic, seq, cnt, chk;
        int                pick;
        start = ($urandom_range(31, 0) == 0);
        if (start) begin
            journal_seq = $urandom_range(1000, 1);
            slot_next   = ($urandom_range(3, 0) == 0) ? SLOT_W'($urandom_range(8191, 0)) : '0;
        end
        slot      = ($urandom_range(49, 0) == 0) ? SLOT_W'($urandom_range(8191, 0)) : slot_next;
        slot_next = slot + 1'b1;
        pick      = $urandom_range(99, 0);
        if (pick < 60) begin
            valid_fields(magic, seq, cnt);
            chk = seal_crc(magic, seq, cnt);
        end else if (pick < 68) begin
            valid_fields(magic, seq, cnt);
            chk = seal_crc(magic, seq, cnt) ^ (32'h1 << $urandom_range(31, 0));
        end else if (pick < 76) begin
            magic = ALL_ONES;
            seq   = ALL_ONES;
            cnt   = ALL_ONES;
            chk   = ALL_ONES;
        end else if (pick < 88) begin
            broken_fields(magic, seq, cnt);
            chk = seal_crc(magic, seq, cnt);
        end else begin
            case ($urandom_range(2, 0))
                0: magic = MAGIC_CURRENT;
                1: magic = MAGIC_LEGACY;
                default: magic = $urandom;
            endcase
            seq = $urandom;
            cnt = $urandom;
            chk = ($urandom_range(3, 0) == 0) ? seal_crc(magic, seq, cnt) : $urandom;
        end
        send_record(start, slot, magic, seq, cnt, chk);
    endtask

    // run limit
    initial begin
        #400000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // reset, directed records, three idling phases, drain, verdict
    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 8;
        rx_idle_pct = 81;

        // records before any scan start build on the reset state
        send_signed(1'b0, 13'd0, MAGIC_CURRENT, 32'd1, 32'd10000);
        send_record(1'b0, 13'd1, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        // legacy marks at their limits
        send_signed(1'b1, 13'd0, MAGIC_LEGACY, 32'd1, 32'd1);
        send_signed(1'b0, 13'd1, MAGIC_LEGACY, 32'd2, 32'd10);
        send_signed(1'b0, 13'd2, MAGIC_LEGACY, 32'd3, 32'd100);
        send_signed(1'b0, 13'd3, MAGIC_LEGACY, 32'd10000002, 32'd1000000000);
        send_signed(1'b0, 13'd4, MAGIC_LEGACY, 32'd2, 32'd1000000100);
        send_signed(1'b0, 13'd5, MAGIC_LEGACY, 32'd10000003, 32'd1000000000);
        // equal sequence, higher count wins
        send_signed(1'b0, 13'd6, MAGIC_CURRENT, 32'd10000002, 32'd4294960000);
        send_signed(1'b0, 13'd7, MAGIC_CURRENT, 32'd0, 32'd10000);
        send_signed(1'b0, 13'd8, MAGIC_CURRENT, 32'd5, 32'd0);
        send_signed(1'b0, 13'd9, MAGIC_CURRENT, 32'd20000, 32'd10000);
        send_signed(1'b0, 13'd10, MAGIC_CURRENT, 32'd5, 32'd15000);
        send_signed(1'b0, 13'd11, 32'h0000_0000, 32'd1, 32'd10000);
        send_record(1'b0, 13'd12, MAGIC_CURRENT, 32'd1, 32'd10000,
                    seal_crc(MAGIC_CURRENT, 32'd1, 32'd10000) ^ 32'h8000_0000);
        // last slot of the sector fills it; almost-erased is not erased
        send_record(1'b0, 13'd8191, ALL_ONES, ALL_ONES, ALL_ONES, 32'hFFFF_FFFE);
        send_record(1'b0, 13'd100, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        // lower slot after a higher one moves the free slot back
        send_record(1'b0, 13'd40, '0, '0, '0, '0);
        send_signed(1'b0, 13'd41, MAGIC_CURRENT, 32'd4294960000, 32'd4294960000);
        send_record(1'b1, 13'd8191, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        send_signed(1'b0, 13'd0, MAGIC_LEGACY, 32'd1, 32'd99);
        send_signed(1'b0, 13'd1, MAGIC_LEGACY, 32'd3, 32'd10);

        repeat (420) random_record();

        tx_idle_pct = 81;
        rx_idle_pct = 8;
        repeat (420) random_record();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (410) random_record();

        @(negedge i_clk);
        i_valid <= 1'b0;

        // drain, then allow the pipeline depth for stray beats
        while (verdicts_pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        if (mismatch_count == 0 && verdicts_pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
